// ----- rtl/core/sorted_set_table_top_macros.svh -----
// assertion macros for the sorted set table
`ifndef SORTED_SET_TABLE_TOP_MACROS_SVH
`define SORTED_SET_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SST_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted set table: same-cycle check failed");
`define SST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted set table: next-cycle check failed");
`else
`define SST_ASSERT_SAME(lbl, ante, cons)
`define SST_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/sst_pkg.sv -----
// shared types and constants for the sorted set table
package sst_pkg;

  localparam int CAPACITY_DEF = 8;
  localparam int MODE_W       = 2;
  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 3;
  localparam int COUNT_W      = 4;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_DUMP      = 3'd6;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] entry_value;
    logic                      is_last;
    logic [COUNT_W-1:0]        count;
  } rsp_t;

  typedef enum logic [1:0] {
    ADDR_IDX,
    ADDR_IDX_DEC,
    ADDR_IDX_INC
  } addr_sel_t;

  typedef struct packed {
    logic                load_req;
    logic                idx_clr;
    logic                idx_inc;
    logic                idx_dec;
    logic                idx_from_cnt;
    logic                pos_from_idx;
    logic                rd_en;
    addr_sel_t           rd_sel;
    logic                wr_en;
    logic                wr_value;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                emit;
    logic                emit_dump;
    logic [STATUS_W-1:0] emit_status;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              is_empty;
    logic              is_full;
    logic              idx_at_cnt;
    logic              idx_at_pos;
    logic              idx_last;
    logic              val_eq;
    logic              val_below;
    logic              out_free;
  } stat_t;

endpackage

// ----- rtl/core/sst_ram.sv -----
// generic single write port, single read port ram with registered read
module sst_ram #(
  parameter int WIDTH = sst_pkg::VALUE_W,
  parameter int DEPTH = sst_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/sst_dp.sv -----
// datapath of the sorted set table: entry ram, counters, compare and result register
module sst_dp #(
  parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  sst_pkg::req_t req,
  input  sst_pkg::cmd_t cmd,
  output sst_pkg::stat_t stat,
  output sst_pkg::rsp_t rsp,
  output logic          rsp_valid,
  input  logic          rsp_stall
);

  import sst_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);

  req_t                req_hold;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    pos;
  logic [CNT_W-1:0]    idx_m1;
  logic [CNT_W-1:0]    idx_p1;
  logic [AW-1:0]       rd_addr;
  logic [VALUE_W-1:0]  rd_data;
  logic [VALUE_W-1:0]  wr_data;
  logic                idx_last;
  rsp_t                rsp_next;

  assign idx_m1   = idx - CNT_W'(1);
  assign idx_p1   = idx + CNT_W'(1);
  assign idx_last = (idx_p1 == cnt);

  always_comb begin
    case (cmd.rd_sel)
      ADDR_IDX:     rd_addr = idx[AW-1:0];
      ADDR_IDX_DEC: rd_addr = idx_m1[AW-1:0];
      ADDR_IDX_INC: rd_addr = idx_p1[AW-1:0];
      default:      rd_addr = idx[AW-1:0];
    endcase
  end

  assign wr_data = cmd.wr_value ? req_hold.value : rd_data;

  sst_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (idx[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    stat.mode       = req_hold.mode;
    stat.is_empty   = (cnt == '0);
    stat.is_full    = (cnt == CNT_W'(CAPACITY));
    stat.idx_at_cnt = (idx == cnt);
    stat.idx_at_pos = (idx == pos);
    stat.idx_last   = idx_last;
    stat.val_eq     = (rd_data == req_hold.value);
    stat.val_below  = ($signed(req_hold.value) < $signed(rd_data));
    stat.out_free   = !rsp_valid || !rsp_stall;
  end

  always_comb begin
    rsp_next.status      = cmd.emit_status;
    rsp_next.entry_value = cmd.emit_dump ? rd_data : '0;
    rsp_next.is_last     = cmd.emit_dump ? idx_last : 1'b1;
    rsp_next.count       = COUNT_W'(cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt <= cnt + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        cnt <= cnt - CNT_W'(1);
      end
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_hold <= req;
    end
    if (cmd.pos_from_idx) begin
      pos <= idx;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_from_cnt) begin
      idx <= cnt;
    end else if (cmd.idx_inc) begin
      idx <= idx_p1;
    end else if (cmd.idx_dec) begin
      idx <= idx_m1;
    end
    if (cmd.emit) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- rtl/core/sst_ctrl.sv -----
// controller state machine of the sorted set table
module sst_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  sst_pkg::stat_t stat,
  output sst_pkg::cmd_t  cmd
);

  import sst_pkg::*;

  typedef enum logic [3:0] {
    IDLE,
    DECIDE,
    SRCH_RD,
    SRCH_CMP,
    INS_RD,
    INS_WR,
    DEL_RD,
    DEL_WR,
    DUMP_RD,
    DUMP_OUT,
    RESULT
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [STATUS_W-1:0] res_status;
  logic [STATUS_W-1:0] res_status_next;

  assign req_stall = (state != IDLE);

  always_comb begin
    cmd             = '0;
    cmd.rd_sel      = ADDR_IDX;
    state_next      = state;
    res_status_next = res_status;
    case (state)
      IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = DECIDE;
        end
      end
      DECIDE: begin
        case (stat.mode)
          MODE_INSERT: begin
            if (stat.is_full) begin
              res_status_next = ST_FULL;
              state_next      = RESULT;
            end else begin
              cmd.idx_clr = 1'b1;
              state_next  = SRCH_RD;
            end
          end
          MODE_DELETE: begin
            if (stat.is_empty) begin
              res_status_next = ST_EMPTY;
              state_next      = RESULT;
            end else begin
              cmd.idx_clr = 1'b1;
              state_next  = SRCH_RD;
            end
          end
          MODE_DUMP: begin
            if (stat.is_empty) begin
              res_status_next = ST_EMPTY;
              state_next      = RESULT;
            end else begin
              cmd.idx_clr = 1'b1;
              state_next  = DUMP_RD;
            end
          end
          default: state_next = IDLE;
        endcase
      end
      SRCH_RD: begin
        if (stat.idx_at_cnt) begin
          if (stat.mode == MODE_INSERT) begin
            cmd.pos_from_idx = 1'b1;
            cmd.idx_from_cnt = 1'b1;
            state_next       = INS_RD;
          end else begin
            res_status_next = ST_NOT_FOUND;
            state_next      = RESULT;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = SRCH_CMP;
        end
      end
      SRCH_CMP: begin
        if (stat.mode == MODE_INSERT) begin
          if (stat.val_eq) begin
            res_status_next = ST_DUPLICATE;
            state_next      = RESULT;
          end else if (stat.val_below) begin
            cmd.pos_from_idx = 1'b1;
            cmd.idx_from_cnt = 1'b1;
            state_next       = INS_RD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = SRCH_RD;
          end
        end else begin
          if (stat.val_eq) begin
            state_next = DEL_RD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = SRCH_RD;
          end
        end
      end
      INS_RD: begin
        if (stat.idx_at_pos) begin
          cmd.wr_en       = 1'b1;
          cmd.wr_value    = 1'b1;
          cmd.cnt_inc     = 1'b1;
          res_status_next = ST_INSERTED;
          state_next      = RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_IDX_DEC;
          state_next = INS_WR;
        end
      end
      INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_dec = 1'b1;
        state_next  = INS_RD;
      end
      DEL_RD: begin
        if (stat.idx_last) begin
          cmd.cnt_dec     = 1'b1;
          res_status_next = ST_REMOVED;
          state_next      = RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_IDX_INC;
          state_next = DEL_WR;
        end
      end
      DEL_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = DEL_RD;
      end
      DUMP_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = DUMP_OUT;
      end
      DUMP_OUT: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_dump   = 1'b1;
          cmd.emit_status = ST_DUMP;
          if (stat.idx_last) begin
            state_next = IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = DUMP_RD;
          end
        end
      end
      RESULT: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = res_status;
          state_next      = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      res_status <= ST_INSERTED;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
    end
  end

endmodule

// ----- rtl/core/sorted_set_table_top.sv -----
// top level of the sorted set table: controller, datapath and checks
// usage:
//   req channel (req_valid, req_stall, req) carries one word: mode and value.
//   mode insert places the value in ascending order, delete removes it,
//   dump returns every stored value in order; the unused mode is dropped.
//   rsp channel (rsp_valid, rsp_stall, rsp) returns status, entry value,
//   last mark and the count after the operation.
//   insert and delete give one rsp word; dump gives one word per stored
//   value (or a single empty word), the final one marked last.
// timing:
//   one word is worked on at a time; req_stall is high from acceptance until
//   the last rsp word has been loaded into the output register.
//   the entry ram has one read port with a registered read, so each entry
//   visited takes a read state and then a compare, write or output state.
// reset and stall:
//   rst clears the count and the output valid; stored entries are not
//   cleared. while rsp_stall is high the rsp word holds and a dump pauses,
//   but a new req word is taken once the final rsp word is registered.
`include "sorted_set_table_top_macros.svh"

module sorted_set_table_top #(
  parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sst_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sst_pkg::rsp_t rsp
);

  import sst_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sst_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  `SST_ASSERT_SAME(a_emit_needs_room, cmd.emit, stat.out_free)
  `SST_ASSERT_SAME(a_no_grow_when_full, cmd.cnt_inc, !stat.is_full)
  `SST_ASSERT_SAME(a_no_shrink_when_empty, cmd.cnt_dec, !stat.is_empty)
  `SST_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

endmodule
